>>> rtl/psc_pkg.sv
// Shared types and constants for the pressure sensor compensation pipeline.
// No dependencies; used by psc_depth and pressure_sensor_compensation_top.
package psc_pkg;

  localparam int unsigned RAW_W     = 24;
  localparam int unsigned COEFF_W   = 16;
  localparam int unsigned TEMP_W    = 19;
  localparam int unsigned PRES_W    = 24;
  localparam int unsigned DEPTH_W   = 22;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned WATER_W   = 23;

  // Temperature reference points in 0.01 degC, relative to 20.00 degC.
  localparam int TEMP_REF = 2000;
  localparam int COLD_REF = 3500;  // 20.00 degC plus 15.00 degC

  localparam int TEMP_MAX  = 262143;
  localparam int TEMP_MIN  = -262144;
  localparam int PRES_MAX  = 8388607;
  localparam int PRES_MIN  = -8388608;
  localparam int DEPTH_MAX = 4194303;

  // Depth: floor((2P - ATM_OFFSET) * DEPTH_SCALE / 20000), 20000 = 32 * 625.
  localparam int ATM_OFFSET      = 20265;
  localparam int DEPTH_SCALE     = 10197;
  localparam int DEPTH_SAT_WATER = 8226546;  // smallest water value that overflows depth
  localparam int DIV_SHIFT       = 5;
  localparam int DIV_ODD         = 625;
  localparam int RECIP_SHIFT     = 32;
  localparam int RECIP_ODD       = 6871947;  // floor(2^32 / 625)

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_SENS_TC   = 3'd2,
    REG_OFFSET_TC = 3'd3,
    REG_TREF      = 3'd4,
    REG_TSLOPE    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic pos;  // water above one atmosphere
    logic big;  // depth overflows its field
  } water_flags_t;

endpackage

>>> rtl/pressure_sensor_compensation_top.sv
// Top level of the barometric sensor compensation pipeline.
// Depends on psc_pkg and psc_depth.

// Converts one raw pressure / raw temperature pair into compensated temperature
// (0.01 degC), pressure (0.1 mbar) and water depth (mm) using six calibration
// words. The datapath is a 13-stage pipeline: one request is taken per cycle
// unless m_axis_tready stalls a full pipeline, so throughput is one item per clock.
// The longest arithmetic is the 24 x 39 bit pressure product, split into two
// partial products in one stage and summed in the next. Each stage holds its
// data while the stage after it is full and stalled, so empty stages still
// fill while m_axis_tready is low. Calibration writes take effect at once and
// should only happen while the pipeline is empty.
module pressure_sensor_compensation_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Calibration write port
  input  logic                          cfg_we_i,
  input  logic [psc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psc_pkg::COEFF_W-1:0]   cfg_data_i,
  // Raw samples
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,  // raw_pressure, raw_temperature
  // Compensated results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [71:0]                   m_axis_tdata   // temperature_centideg,
                                                       // pressure_decimbar, depth_mm, zeros
);
  import psc_pkg::*;

  localparam int NSTAGE = 13;

  // Calibration words
  logic [COEFF_W-1:0] c_sens_q, c_off_q, c_sens_tc_q, c_off_tc_q, c_tref_q, c_tslope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_sens_q    <= '0;
      c_off_q     <= '0;
      c_sens_tc_q <= '0;
      c_off_tc_q  <= '0;
      c_tref_q    <= '0;
      c_tslope_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SENS:      c_sens_q    <= cfg_data_i;
        REG_OFFSET:    c_off_q     <= cfg_data_i;
        REG_SENS_TC:   c_sens_tc_q <= cfg_data_i;
        REG_OFFSET_TC: c_off_tc_q  <= cfg_data_i;
        REG_TREF:      c_tref_q    <= cfg_data_i;
        REG_TSLOPE:    c_tslope_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor loads.
  logic [NSTAGE-1:0] v_q, v_d, v_in, en;

  always_comb begin
    en[NSTAGE-1] = !v_q[NSTAGE-1] || m_axis_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NSTAGE-2:0], s_axis_tvalid};
  assign v_d  = (en & v_in) | (~en & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NSTAGE-1];

  // Stage 0: dT
  logic [RAW_W-1:0]  raw_p, raw_t;
  logic signed [24:0] s0_dt_d, s0_dt_q;
  logic [RAW_W-1:0]  s0_d1_q, s1_d1_q, s2_d1_q, s3_d1_q, s4_d1_q, s5_d1_q;

  assign raw_p   = s_axis_tdata[23:0];
  assign raw_t   = s_axis_tdata[47:24];
  assign s0_dt_d = $signed({1'b0, raw_t}) - $signed({1'b0, c_tref_q, 8'h00});

  // Stage 1: first-order products and dT squared
  logic signed [41:0] s1_m6_d, s1_m4_d, s1_m3_d, s1_m6_q, s1_m4_q, s1_m3_q;
  logic signed [49:0] s1_sq;
  logic [47:0]        s1_dtsq_q;

  assign s1_m6_d = s0_dt_q * $signed({1'b0, c_tslope_q});
  assign s1_m4_d = s0_dt_q * $signed({1'b0, c_off_tc_q});
  assign s1_m3_d = s0_dt_q * $signed({1'b0, c_sens_tc_q});
  assign s1_sq   = s0_dt_q * s0_dt_q;

  // Stage 2: TEMP, OFF, SENS, Ti and temperature band
  logic signed [18:0] s2_tdev_d, s2_tdev_q;
  logic [19:0]        s2_temp, s2_tcold_d, s2_tcold_q;
  logic [49:0]        s2_tri;
  logic [16:0]        s2_ti;
  logic [20:0]        s2_tcomp_d, s2_tcomp_q;
  logic [35:0]        s2_off_d, s2_off_q, s3_off_q, s4_off_q;
  logic [34:0]        s2_sens_d, s2_sens_q, s3_sens_q, s4_sens_q;
  logic               s2_below_q, s2_vcold_q, s3_below_q;

  always_comb begin
    s2_tdev_d  = s1_m6_q[41:23];
    s2_temp    = {s2_tdev_d[18], s2_tdev_d} + 20'(TEMP_REF);
    s2_tcold_d = {s2_tdev_d[18], s2_tdev_d} + 20'(COLD_REF);
    s2_tri     = {2'b00, s1_dtsq_q} + {1'b0, s1_dtsq_q, 1'b0};
    // Low band uses 3*dT^2 >> 33, high band 2*dT^2 >> 37.
    s2_ti      = s2_tdev_d[18] ? s2_tri[49:33] : {5'b0, s1_dtsq_q[47:36]};
    s2_tcomp_d = {s2_temp[19], s2_temp} - {4'b0, s2_ti};
    s2_off_d   = {4'b0, c_off_q, 16'h0000} + {s1_m4_q[41], s1_m4_q[41:7]};
    s2_sens_d  = {4'b0, c_sens_q, 15'h0000} + {s1_m3_q[41], s1_m3_q[41:8]};
  end

  // Stage 3: squared temperature deviations, temperature saturation
  logic signed [37:0] s3_hsq;
  logic signed [39:0] s3_csq;
  logic [34:0]        s3_hot_q, s3_cold_d, s3_cold_q;
  logic [TEMP_W-1:0]  s3_tsat_d;
  logic [TEMP_W-1:0]  s3_tsat_q, s4_tsat_q, s5_tsat_q, s6_tsat_q, s7_tsat_q, s8_tsat_q;
  logic [TEMP_W-1:0]  s9_tsat_q, s10_tsat_q, s11_tsat_q, s12_tsat_q;

  assign s3_hsq    = s2_tdev_q * s2_tdev_q;
  assign s3_csq    = $signed(s2_tcold_q) * $signed(s2_tcold_q);
  assign s3_cold_d = s2_vcold_q ? s3_csq[34:0] : '0;

  always_comb begin
    if ($signed(s2_tcomp_q) > TEMP_MAX) begin
      s3_tsat_d = TEMP_W'(TEMP_MAX);
    end else if ($signed(s2_tcomp_q) < TEMP_MIN) begin
      s3_tsat_d = TEMP_W'(TEMP_MIN);
    end else begin
      s3_tsat_d = s2_tcomp_q[TEMP_W-1:0];
    end
  end

  // Stage 4: second-order offset and sensitivity corrections
  logic [36:0] s4_h3, s4_c4;
  logic [37:0] s4_h5, s4_c7;
  logic [38:0] s4_offi_d, s4_offi_q;
  logic [37:0] s4_sensi_d, s4_sensi_q;

  always_comb begin
    s4_h3 = {2'b00, s3_hot_q} + {1'b0, s3_hot_q, 1'b0};
    s4_h5 = {3'b000, s3_hot_q} + {1'b0, s3_hot_q, 2'b00};
    s4_c7 = {s3_cold_q, 3'b000} - {3'b000, s3_cold_q};
    s4_c4 = {s3_cold_q, 2'b00};
    if (s3_below_q) begin
      s4_offi_d  = {3'b000, s4_h3[36:1]} + {1'b0, s4_c7};
      s4_sensi_d = {3'b000, s4_h5[37:3]} + {1'b0, s4_c4};
    end else begin
      s4_offi_d  = {8'h00, s3_hot_q[34:4]};
      s4_sensi_d = '0;
    end
  end

  // Stage 5: corrected OFF and SENS
  logic [39:0] s5_off2_d, s5_off2_q, s6_off2_q, s7_off2_q;
  logic [38:0] s5_sens2_d, s5_sens2_q;

  assign s5_off2_d  = {{4{s4_off_q[35]}}, s4_off_q} - {1'b0, s4_offi_q};
  assign s5_sens2_d = {{4{s4_sens_q[34]}}, s4_sens_q} - {1'b0, s4_sensi_q};

  // Stage 6: D1 * SENS as two partial products
  logic [19:0]        s6_lo;
  logic signed [18:0] s6_hi;
  logic [43:0]        s6_plo_d, s6_plo_q;
  logic signed [43:0] s6_phi_d, s6_phi_q;

  assign s6_lo    = s5_sens2_q[19:0];
  assign s6_hi    = s5_sens2_q[38:20];
  assign s6_plo_d = 44'(s5_d1_q) * 44'(s6_lo);
  assign s6_phi_d = $signed({1'b0, s5_d1_q}) * s6_hi;

  // Stage 7: combine partial products
  logic [63:0] s7_prod_d, s7_prod_q;

  assign s7_prod_d = {s6_phi_q, 20'h00000} + {20'h00000, s6_plo_q};

  // Stage 8: P = ((D1*SENS >> 21) - OFF) >> 13
  logic [43:0] s8_diff;
  logic [30:0] s8_p_d, s8_p_q;

  assign s8_diff = {s7_prod_q[63], s7_prod_q[63:21]} - {{4{s7_off2_q[39]}}, s7_off2_q};
  assign s8_p_d  = s8_diff[43:13];

  // Stage 9: pressure saturation and water level
  logic [PRES_W-1:0]  s9_psat_d;
  logic [PRES_W-1:0]  s9_psat_q, s10_psat_q, s11_psat_q, s12_psat_q;
  logic [32:0]        s9_water;
  water_flags_t       s9_flags_d, s9_flags_q;
  logic [WATER_W-1:0] s9_water_q;

  always_comb begin
    if ($signed(s8_p_q) > PRES_MAX) begin
      s9_psat_d = PRES_W'(PRES_MAX);
    end else if ($signed(s8_p_q) < PRES_MIN) begin
      s9_psat_d = PRES_W'(PRES_MIN);
    end else begin
      s9_psat_d = s8_p_q[PRES_W-1:0];
    end
    s9_water       = {s8_p_q[30], s8_p_q, 1'b0} - 33'(ATM_OFFSET);
    s9_flags_d.pos = !s9_water[32] && (|s9_water);
    s9_flags_d.big = $signed(s9_water) >= DEPTH_SAT_WATER;
  end

  // Stages 10 to 12: depth
  logic [DEPTH_W-1:0] depth;

  psc_depth u_depth (
    .clk_i   (clk_i),
    .en_i    (en[12:10]),
    .water_i (s9_water_q),
    .flags_i (s9_flags_q),
    .depth_o (depth)
  );

  // Stage data registers
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_dt_q <= s0_dt_d;
      s0_d1_q <= raw_p;
    end
    if (en[1]) begin
      s1_m6_q   <= s1_m6_d;
      s1_m4_q   <= s1_m4_d;
      s1_m3_q   <= s1_m3_d;
      s1_dtsq_q <= s1_sq[47:0];
      s1_d1_q   <= s0_d1_q;
    end
    if (en[2]) begin
      s2_tdev_q  <= s2_tdev_d;
      s2_tcold_q <= s2_tcold_d;
      s2_below_q <= s2_tdev_d[18];
      s2_vcold_q <= s2_tcold_d[19];
      s2_tcomp_q <= s2_tcomp_d;
      s2_off_q   <= s2_off_d;
      s2_sens_q  <= s2_sens_d;
      s2_d1_q    <= s1_d1_q;
    end
    if (en[3]) begin
      s3_hot_q   <= s3_hsq[34:0];
      s3_cold_q  <= s3_cold_d;
      s3_below_q <= s2_below_q;
      s3_tsat_q  <= s3_tsat_d;
      s3_off_q   <= s2_off_q;
      s3_sens_q  <= s2_sens_q;
      s3_d1_q    <= s2_d1_q;
    end
    if (en[4]) begin
      s4_offi_q  <= s4_offi_d;
      s4_sensi_q <= s4_sensi_d;
      s4_off_q   <= s3_off_q;
      s4_sens_q  <= s3_sens_q;
      s4_tsat_q  <= s3_tsat_q;
      s4_d1_q    <= s3_d1_q;
    end
    if (en[5]) begin
      s5_off2_q  <= s5_off2_d;
      s5_sens2_q <= s5_sens2_d;
      s5_tsat_q  <= s4_tsat_q;
      s5_d1_q    <= s4_d1_q;
    end
    if (en[6]) begin
      s6_plo_q  <= s6_plo_d;
      s6_phi_q  <= s6_phi_d;
      s6_off2_q <= s5_off2_q;
      s6_tsat_q <= s5_tsat_q;
    end
    if (en[7]) begin
      s7_prod_q <= s7_prod_d;
      s7_off2_q <= s6_off2_q;
      s7_tsat_q <= s6_tsat_q;
    end
    if (en[8]) begin
      s8_p_q    <= s8_p_d;
      s8_tsat_q <= s7_tsat_q;
    end
    if (en[9]) begin
      s9_psat_q  <= s9_psat_d;
      s9_water_q <= s9_water[WATER_W-1:0];
      s9_flags_q <= s9_flags_d;
      s9_tsat_q  <= s8_tsat_q;
    end
    if (en[10]) begin
      s10_psat_q <= s9_psat_q;
      s10_tsat_q <= s9_tsat_q;
    end
    if (en[11]) begin
      s11_psat_q <= s10_psat_q;
      s11_tsat_q <= s10_tsat_q;
    end
    if (en[12]) begin
      s12_psat_q <= s11_psat_q;
      s12_tsat_q <= s11_tsat_q;
    end
  end

  assign m_axis_tdata = {7'b0, depth, s12_psat_q, s12_tsat_q};

endmodule

>>> rtl/psc_depth.sv
// Three-stage depth conversion: water level times scale, divided by 20000, clamped to 0 and DEPTH_MAX.
// Depends on psc_pkg; stage enables come from the top-level pipeline control.
module psc_depth (
  input  logic                               clk_i,
  input  logic [2:0]                         en_i,
  input  logic [psc_pkg::WATER_W-1:0]        water_i,
  input  psc_pkg::water_flags_t              flags_i,
  output logic [psc_pkg::DEPTH_W-1:0]        depth_o
);
  import psc_pkg::*;

  localparam int unsigned PROD_W = WATER_W + 14;
  localparam int unsigned M_W    = PROD_W - DIV_SHIFT;
  localparam int unsigned RP_W   = M_W + 23;

  logic [PROD_W-1:0]  s10_n_d, s10_n_q;
  water_flags_t       s10_flags_q, s11_flags_q;
  logic [M_W-1:0]     s11_m_d, s11_m_q;
  logic [RP_W-1:0]    s11_rp;
  logic [DEPTH_W-1:0] s11_qe_d, s11_qe_q;
  logic [M_W-1:0]     s12_qm, s12_rem;
  logic [DEPTH_W-1:0] s12_q, s12_depth_d, s12_depth_q;

  assign s10_n_d = PROD_W'(water_i) * PROD_W'(DEPTH_SCALE);

  // Quotient estimate by reciprocal; it is low by at most one.
  assign s11_m_d  = s10_n_q[PROD_W-1:DIV_SHIFT];
  assign s11_rp   = RP_W'(s11_m_d) * RP_W'(RECIP_ODD);
  assign s11_qe_d = s11_rp[RECIP_SHIFT +: DEPTH_W];

  always_comb begin
    s12_qm  = M_W'(s11_qe_q) * M_W'(DIV_ODD);
    s12_rem = s11_m_q - s12_qm;
    s12_q   = s11_qe_q + DEPTH_W'(s12_rem >= M_W'(DIV_ODD));
    if (!s11_flags_q.pos) begin
      s12_depth_d = '0;
    end else if (s11_flags_q.big) begin
      s12_depth_d = DEPTH_W'(DEPTH_MAX);
    end else begin
      s12_depth_d = s12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s10_n_q     <= s10_n_d;
      s10_flags_q <= flags_i;
    end
    if (en_i[1]) begin
      s11_m_q     <= s11_m_d;
      s11_qe_q    <= s11_qe_d;
      s11_flags_q <= s10_flags_q;
    end
    if (en_i[2]) begin
      s12_depth_q <= s12_depth_d;
    end
  end

  assign depth_o = s12_depth_q;

endmodule
